[rtl/core/cpr_pkg.sv]
// Shared types, constants and helper functions for the complex polar/rect unit.
// No dependencies.
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int GUARD             = 24;
  localparam int SQRT_STEPS        = 32;
  localparam int XW                = 60;  // CORDIC x/y width
  localparam int ZW                = 44;  // CORDIC angle width, 32 fraction bits
  localparam int NQ_W              = 56;  // divider numerator/quotient width
  localparam int RW                = 36;  // reduced angle width

  localparam logic [31:0] GAIN  = 32'd2608131496;
  localparam logic [31:0] RECIP = 32'd3054198967;  // ceil(2^40 / 360)

  typedef enum logic [2:0] {
    MODE_TO_POLAR = 3'd0,
    MODE_TO_RECT  = 3'd1,
    MODE_ADD      = 3'd2,
    MODE_SUB      = 3'd3,
    MODE_MUL      = 3'd4,
    MODE_DIV      = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIVZ = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic               flag;
    logic signed [31:0] val;
  } sat_t;

  typedef struct packed {
    logic [2:0]            mode;
    logic signed [31:0]    r1;
    logic signed [31:0]    r2;
    logic                  sat;
    logic                  vect;
    logic                  flip;
    logic                  zero;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic signed [ZW-1:0]  z;
    logic [63:0]           v;
    logic [63:0]           res;
    logic [31:0]           rem;
    logic [31:0]           den;
    logic [NQ_W-1:0]       nq;
    logic                  neg;
    logic                  divz;
  } item_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t s;
    if (v > 64'sd2147483647) begin
      s.flag = 1'b1;
      s.val  = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      s.flag = 1'b1;
      s.val  = 32'sh80000000;
    end else begin
      s.flag = 1'b0;
      s.val  = v[31:0];
    end
    return s;
  endfunction

  // atan(2^-idx) in degrees, 32 fraction bits, from the arctangent series
  function automatic logic signed [63:0] atan_deg(input int idx);
    logic [63:0]        dq;
    logic signed [63:0] sum;
    logic signed [63:0] t;
    int                 k;
    int                 sh;
    dq  = 64'd246083499208 * 64'd16777216;
    sum = '0;
    k   = 0;
    if (idx == 0) begin
      return 64'sd45 <<< 32;
    end
    for (sh = idx; sh < 64; sh = sh + 2 * idx) begin
      t = $signed((dq >> sh) / 64'(2 * k + 1));
      if (k[0]) begin
        sum = sum - t;
      end else begin
        sum = sum + t;
      end
      k = k + 1;
    end
    return (sum + 64'sd8388608) >>> 24;
  endfunction

endpackage

[rtl/core/cpr_ifs.sv]
// Request and response channel interfaces of the complex polar/rect unit.
// No dependencies.
`timescale 1ns / 1ps

interface cpr_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [31:0] first_a;
  logic signed [31:0] second_a;
  logic signed [31:0] first_b;
  logic signed [31:0] second_b;

  modport source (output valid, mode, first_a, second_a, first_b, second_b, input ready);
  modport sink   (input valid, mode, first_a, second_a, first_b, second_b, output ready);
endinterface

interface cpr_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_first;
  logic signed [31:0] result_second;
  logic [1:0]         status;

  modport source (output valid, result_first, result_second, status, input ready);
  modport sink   (input valid, result_first, result_second, status, output ready);
endinterface

[rtl/core/complex_polar_rect_alu_top.sv]
// Complex polar/rect unit: one pipeline from request to response.
// One request per cycle while not held; the depth is set by the cell chain, one quotient bit per
// cell (32 + FRAC_BITS cells), plus three setup stages and one output register.
// The whole pipeline holds while a response waits and is not taken.
// Reset clears the valid bits only; no clearing pass.
`timescale 1ns / 1ps

module complex_polar_rect_alu_top
  import cpr_pkg::*;
#(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  cpr_req_if.sink   req,
  cpr_rsp_if.source rsp
);

  localparam int NCELL = 32 + FRAC_BITS;

  logic  en;
  logic  rsp_vld;
  logic  cvld  [NCELL+1];
  item_t chain [NCELL+1];

  assign en        = !rsp_vld || rsp.ready;
  assign req.ready = en;
  assign rsp.valid = rsp_vld;

  cpr_prep #(
    .FRAC_BITS(FRAC_BITS)
  ) u_prep (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (req.valid),
    .mode    (req.mode),
    .a1      (req.first_a),
    .a2      (req.second_a),
    .b1      (req.first_b),
    .b2      (req.second_b),
    .out_vld (cvld[0]),
    .out_item(chain[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    cpr_cell #(
      .STAGE        (g),
      .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (cvld[g]),
      .in_item (chain[g]),
      .out_vld (cvld[g+1]),
      .out_item(chain[g+1])
    );
  end

  cpr_post #(
    .FRAC_BITS(FRAC_BITS)
  ) u_post (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_vld       (cvld[NCELL]),
    .in_item      (chain[NCELL]),
    .out_vld      (rsp_vld),
    .result_first (rsp.result_first),
    .result_second(rsp.result_second),
    .status       (rsp.status)
  );

endmodule

[rtl/core/cpr_prep.sv]
// Three-stage front end: products, angle reduction, simple results, CORDIC/divider setup.
// Depends on cpr_pkg.
`timescale 1ns / 1ps

module cpr_prep
  import cpr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  logic [2:0]         mode,
  input  logic signed [31:0] a1,
  input  logic signed [31:0] a2,
  input  logic signed [31:0] b1,
  input  logic signed [31:0] b2,
  output logic               out_vld,
  output item_t              out_item
);

  localparam logic signed [RW-1:0] TURN    = RW'(360) <<< FRAC_BITS;
  localparam logic signed [RW-1:0] HALF    = RW'(180) <<< FRAC_BITS;
  localparam logic signed [RW-1:0] QUARTER = RW'(90) <<< FRAC_BITS;
  localparam logic signed [63:0]   RND     = 64'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic signed [63:0] sq_re;
    logic signed [63:0] sq_im;
    logic signed [63:0] prod;
    logic signed [63:0] gainp;
    logic signed [31:0] qe;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
    logic               sat;
    logic [31:0]        numa;
    logic [31:0]        den;
    logic               neg;
    logic               divz;
  } s1_t;

  typedef struct packed {
    logic [2:0]          mode;
    logic signed [31:0]  a1;
    logic signed [31:0]  a2;
    logic [63:0]         sumsq;
    logic signed [63:0]  gainp;
    logic signed [RW-1:0] rraw;
    logic signed [31:0]  r1;
    logic signed [31:0]  r2;
    logic                sat;
    logic [31:0]         numa;
    logic [31:0]         den;
    logic                neg;
    logic                divz;
  } s2_t;

  s1_t   s1, s1_next;
  s2_t   s2, s2_next;
  item_t it_next;
  logic  v1, v2;

  logic signed [64:0] gp, pq;
  logic signed [63:0] sum_f, sum_s, dif_f, dif_s, rprod, qt;
  sat_t               st_a, st_b, st_m;
  logic signed [RW-1:0] rc, rh, rq;
  logic               fl;

  always_comb begin
    gp    = a1 * $signed({1'b0, GAIN});
    pq    = a2 * $signed({1'b0, RECIP});
    sum_f = 64'(a1) + 64'(b1);
    sum_s = 64'(a2) + 64'(b2);
    dif_f = 64'(a1) - 64'(b1);
    dif_s = 64'(a2) - 64'(b2);
    s1_next.mode  = mode;
    s1_next.a1    = a1;
    s1_next.a2    = a2;
    s1_next.sq_re = 64'(a1) * 64'(a1);
    s1_next.sq_im = 64'(a2) * 64'(a2);
    s1_next.prod  = 64'(a1) * 64'(b1);
    s1_next.gainp = gp[63:0];
    s1_next.qe    = 32'(pq >>> (40 + FRAC_BITS));
    s1_next.numa  = a1[31] ? 32'(-a1) : 32'(a1);
    s1_next.den   = b1[31] ? 32'(-b1) : 32'(b1);
    s1_next.neg   = a1[31] ^ b1[31];
    s1_next.divz  = (b1 == '0);
    if (mode == MODE_ADD) begin
      st_a = sat32(sum_f);
      st_b = sat32(sum_s);
    end else if (mode == MODE_SUB) begin
      st_a = sat32(dif_f);
      st_b = sat32(dif_s);
    end else if (mode == MODE_MUL) begin
      st_a = '0;
      st_b = sat32(sum_s);
    end else if (mode == MODE_DIV) begin
      st_a = '0;
      st_b = sat32(dif_s);
    end else begin
      st_a = '0;
      st_b = '0;
    end
    s1_next.r1  = st_a.val;
    s1_next.r2  = st_b.val;
    s1_next.sat = st_a.flag | st_b.flag;
  end

  always_comb begin
    rprod = (s1.prod + RND) >>> FRAC_BITS;
    st_m  = sat32(rprod);
    qt    = 64'(s1.qe) * 64'(TURN);
    s2_next.mode  = s1.mode;
    s2_next.a1    = s1.a1;
    s2_next.a2    = s1.a2;
    s2_next.sumsq = 64'(s1.sq_re) + 64'(s1.sq_im);
    s2_next.gainp = s1.gainp;
    s2_next.rraw  = RW'(64'(s1.a2) - qt);
    s2_next.numa  = s1.numa;
    s2_next.den   = s1.den;
    s2_next.neg   = s1.neg;
    s2_next.divz  = s1.divz;
    s2_next.r2    = s1.r2;
    if (s1.mode == MODE_MUL) begin
      s2_next.r1  = st_m.val;
      s2_next.sat = s1.sat | st_m.flag;
    end else begin
      s2_next.r1  = s1.r1;
      s2_next.sat = s1.sat;
    end
  end

  always_comb begin
    if (s2.rraw < 0) begin
      rc = s2.rraw + TURN;
    end else if (s2.rraw >= TURN) begin
      rc = s2.rraw - TURN;
    end else begin
      rc = s2.rraw;
    end
    rh = (rc > HALF) ? rc - TURN : rc;
    if (rh > QUARTER) begin
      rq = rh - HALF;
      fl = 1'b1;
    end else if (rh < -QUARTER) begin
      rq = rh + HALF;
      fl = 1'b1;
    end else begin
      rq = rh;
      fl = 1'b0;
    end
    it_next.mode = s2.mode;
    it_next.r1   = s2.r1;
    it_next.r2   = s2.r2;
    it_next.sat  = s2.sat;
    it_next.vect = (s2.mode == MODE_TO_POLAR);
    it_next.zero = (s2.a1 == '0) && (s2.a2 == '0);
    it_next.v    = s2.sumsq;
    it_next.res  = '0;
    it_next.rem  = '0;
    it_next.den  = s2.den;
    it_next.nq   = {s2.numa, {(NQ_W - 32){1'b0}}};
    it_next.neg  = s2.neg;
    it_next.divz = s2.divz;
    if (s2.mode == MODE_TO_POLAR) begin
      it_next.flip = 1'b0;
      if (s2.a1[31]) begin
        it_next.x = -(XW'(s2.a1) <<< GUARD);
        it_next.y = -(XW'(s2.a2) <<< GUARD);
        it_next.z = s2.a2[31] ? -(ZW'(180) <<< 32) : (ZW'(180) <<< 32);
      end else begin
        it_next.x = XW'(s2.a1) <<< GUARD;
        it_next.y = XW'(s2.a2) <<< GUARD;
        it_next.z = '0;
      end
    end else begin
      it_next.flip = fl;
      it_next.x    = XW'(s2.gainp >>> (32 - GUARD));
      it_next.y    = '0;
      it_next.z    = ZW'(rq) <<< (32 - FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      v2      <= v1;
      out_vld <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1       <= s1_next;
      s2       <= s2_next;
      out_item <= it_next;
    end
  end

endmodule

[rtl/core/cpr_cell.sv]
// Chain cell: a quotient bit, a CORDIC micro-rotation if STAGE < CORDIC_STAGES and a
// square-root digit if STAGE < SQRT_STEPS. Depends on cpr_pkg.
`timescale 1ns / 1ps

module cpr_cell
  import cpr_pkg::*;
#(
  parameter int STAGE         = 0,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_vld,
  input  item_t in_item,
  output logic  out_vld,
  output item_t out_item
);

  localparam logic signed [ZW-1:0] ATAN  = ZW'(atan_deg(STAGE));
  localparam bit                   DO_CR = (STAGE < CORDIC_STAGES);
  localparam bit                   DO_SQ = (STAGE < SQRT_STEPS);
  localparam int                   SQ_SH = DO_SQ ? 62 - 2 * STAGE : 0;
  localparam logic [63:0]          SQ_BIT = DO_SQ ? (64'd1 << SQ_SH) : 64'd0;

  item_t                it_next;
  logic signed [XW-1:0] dx, dy;
  logic                 rot_pos;
  logic [63:0]          tot;
  logic [32:0]          tmp;
  logic                 ge;

  always_comb begin
    it_next = in_item;
    dx      = in_item.y >>> STAGE;
    dy      = in_item.x >>> STAGE;
    rot_pos = in_item.vect ? in_item.y[XW-1] : !in_item.z[ZW-1];
    if (DO_CR) begin
      if (rot_pos) begin
        it_next.x = in_item.x - dx;
        it_next.y = in_item.y + dy;
        it_next.z = in_item.z - ATAN;
      end else begin
        it_next.x = in_item.x + dx;
        it_next.y = in_item.y - dy;
        it_next.z = in_item.z + ATAN;
      end
    end
    tot = in_item.res + SQ_BIT;
    if (DO_SQ) begin
      if (in_item.v >= tot) begin
        it_next.v   = in_item.v - tot;
        it_next.res = (in_item.res >> 1) + SQ_BIT;
      end else begin
        it_next.res = in_item.res >> 1;
      end
    end
    tmp = {in_item.rem, in_item.nq[NQ_W-1]};
    ge  = (tmp >= {1'b0, in_item.den});
    it_next.rem = ge ? 32'(tmp - {1'b0, in_item.den}) : tmp[31:0];
    it_next.nq  = {in_item.nq[NQ_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= it_next;
    end
  end

endmodule

[rtl/core/cpr_post.sv]
// Output stage: rounding, angle wrap, quotient sign, saturation, mode select, result register.
// Depends on cpr_pkg.
`timescale 1ns / 1ps

module cpr_post
  import cpr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  item_t              in_item,
  output logic               out_vld,
  output logic signed [31:0] result_first,
  output logic signed [31:0] result_second,
  output logic [1:0]         status
);

  localparam logic signed [ZW-1:0] ZRND = ZW'(1) <<< (31 - FRAC_BITS);
  localparam logic signed [ZW-1:0] FULL = ZW'(180) <<< FRAC_BITS;
  localparam logic signed [XW-1:0] XRND = XW'(1) <<< (GUARD - 1);

  logic signed [ZW-1:0] zr, zw;
  logic [63:0]          magv;
  logic signed [XW-1:0] xr, yr;
  logic signed [NQ_W+1:0] qv, qs;
  sat_t                 ms, xs, ys, dq;
  logic signed [31:0]   f_next, s_next;
  logic [1:0]           st_next;

  always_comb begin
    zr = (in_item.z + ZRND) >>> (32 - FRAC_BITS);
    if (zr > FULL) begin
      zw = zr - (FULL <<< 1);
    end else if (zr <= -FULL) begin
      zw = zr + (FULL <<< 1);
    end else begin
      zw = zr;
    end
    magv = in_item.res + {63'b0, (in_item.v > in_item.res)};
    ms   = sat32($signed(magv));
    xr   = (in_item.x + XRND) >>> GUARD;
    yr   = (in_item.y + XRND) >>> GUARD;
    if (in_item.flip) begin
      xr = -xr;
      yr = -yr;
    end
    xs = sat32(64'(xr));
    ys = sat32(64'(yr));
    qv = $signed({2'b00, in_item.nq});
    qs = in_item.neg ? -qv : qv;
    dq = sat32(64'(qs));
    unique case (in_item.mode)
      MODE_TO_POLAR: begin
        f_next  = ms.val;
        s_next  = in_item.zero ? 32'sd0 : zw[31:0];
        st_next = ms.flag ? STAT_SAT : STAT_OK;
      end
      MODE_TO_RECT: begin
        f_next  = xs.val;
        s_next  = ys.val;
        st_next = (xs.flag | ys.flag) ? STAT_SAT : STAT_OK;
      end
      MODE_ADD, MODE_SUB, MODE_MUL: begin
        f_next  = in_item.r1;
        s_next  = in_item.r2;
        st_next = in_item.sat ? STAT_SAT : STAT_OK;
      end
      MODE_DIV: begin
        if (in_item.divz) begin
          f_next  = '0;
          s_next  = '0;
          st_next = STAT_DIVZ;
        end else begin
          f_next  = dq.val;
          s_next  = in_item.r2;
          st_next = (dq.flag | in_item.sat) ? STAT_SAT : STAT_OK;
        end
      end
      default: begin
        f_next  = '0;
        s_next  = '0;
        st_next = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_first  <= f_next;
      result_second <= s_next;
      status        <= st_next;
    end
  end

endmodule
